/* src/fat_chain_allocator_assert.svh */
// Assertion macros for the chain allocator checker.
// Needs signals named clk and arst_n in the scope of use.
`ifndef FAT_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication
`define FCA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("chain allocator check failed");

// Next-cycle implication
`define FCA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("chain allocator check failed");

`endif

/* src/fca_pkg.sv */
// Shared types, codes and constants of the chain allocator.
// No dependencies.
`default_nettype none

package fca_pkg;

	localparam int MAX_ENTRIES = 4096;
	localparam int ENTRIES_PER_CLUSTER = 512;
	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int VW = 13;
	localparam int OW = 3;
	localparam int SW = 3;

	// Operation codes
	localparam logic [OW-1:0] OP_FORMAT = 3'd0;
	localparam logic [OW-1:0] OP_ALLOC = 3'd1;
	localparam logic [OW-1:0] OP_RESIZE = 3'd2;
	localparam logic [OW-1:0] OP_FREE = 3'd3;
	localparam logic [OW-1:0] OP_COUNT = 3'd4;
	localparam logic [OW-1:0] OP_NEXT = 3'd5;
	localparam logic [OW-1:0] OP_CLUSTER = 3'd6;

	// Result status codes
	localparam logic [SW-1:0] ST_OK = 3'd0;
	localparam logic [SW-1:0] ST_ZERO = 3'd1;
	localparam logic [SW-1:0] ST_NOSPACE = 3'd2;
	localparam logic [SW-1:0] ST_RANGE = 3'd3;
	localparam logic [SW-1:0] ST_END = 3'd4;

	// Datapath actions
	typedef enum logic [3:0] {
		A_NONE,
		A_LOAD,
		A_INIT_CHAIN,
		A_INIT_ALLOC,
		A_INIT_GROW,
		A_STEP_LEN,
		A_STEP_ALLOC,
		A_MARK_CUT,
		A_FMT_STEP,
		A_ALLOC_COMMIT,
		A_GROW_LINK,
		A_WR_CUT,
		A_WR_END
	} act_t;

	// Result value source
	typedef enum logic [2:0] {
		V_ZERO,
		V_HEAD,
		V_CNT,
		V_LEN,
		V_RD,
		V_CLU
	} vsel_t;

	typedef struct packed {
		act_t act;
		logic res_ld;
		logic [SW-1:0] st;
		vsel_t vsel;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic [OW-1:0] op;
		logic cnt_zero;
		logic ent_zero;
		logic ent_rng;
		logic fh_zero;
		logic fh_rng;
		logic rd_zero;
		logic rd_rng;
		logic len_eq_cnt;
		logic len_full;
		logic vis_full;
		logic k_one;
		logic fmt_last;
	} dp_stat_t;

endpackage

`default_nettype wire

/* src/fca_if.sv */
// Valid/ready channel interfaces for the chain allocator.
// Depends on fca_pkg for field widths.
`default_nettype none

interface fca_in_if;
	logic valid;
	logic ready;
	logic [fca_pkg::OW-1:0] op;
	logic [fca_pkg::AW-1:0] entry;
	logic [fca_pkg::CW-1:0] count;
	modport source (output valid, output op, output entry, output count, input ready);
	modport sink (input valid, input op, input entry, input count, output ready);
endinterface

interface fca_out_if;
	logic valid;
	logic ready;
	logic [fca_pkg::SW-1:0] status;
	logic [fca_pkg::VW-1:0] value;
	modport source (output valid, output status, output value, input ready);
	modport sink (input valid, input status, input value, output ready);
endinterface

`default_nettype wire

/* src/fca_ctrl.sv */
// Controller state machine of the chain allocator.
// Depends on fca_pkg; drives the datapath fca_dp by command.
`default_nettype none

module fca_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire fca_pkg::dp_stat_t stat,
	output fca_pkg::cmd_t cmd
);

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_DEC = 15'b000000000000010,
		S_FMT = 15'b000000000000100,
		S_CHK_RD = 15'b000000000001000,
		S_CHK_EV = 15'b000000000010000,
		S_ALLOC_RD = 15'b000000000100000,
		S_ALLOC_EV = 15'b000000001000000,
		S_GROW_WR = 15'b000000010000000,
		S_WALK_RD = 15'b000000100000000,
		S_WALK_EV = 15'b000001000000000,
		S_CUT_WR = 15'b000010000000000,
		S_END_WR = 15'b000100000000000,
		S_NL_RD = 15'b001000000000000,
		S_NL_EV = 15'b010000000000000,
		S_DONE = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '{act: fca_pkg::A_NONE, res_ld: 1'b0, st: fca_pkg::ST_OK,
			vsel: fca_pkg::V_ZERO, out_ld: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.act = fca_pkg::A_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.res_ld = 1'b1;
				state_d = S_DONE;
				case (stat.op) inside
					fca_pkg::OP_FORMAT: begin
						cmd.res_ld = 1'b0;
						state_d = S_FMT;
					end
					fca_pkg::OP_ALLOC: begin
						if (stat.cnt_zero) cmd.st = fca_pkg::ST_ZERO;
						else if (stat.fh_zero) cmd.st = fca_pkg::ST_NOSPACE;
						else if (stat.fh_rng) cmd.st = fca_pkg::ST_RANGE;
						else begin
							cmd.res_ld = 1'b0;
							cmd.act = fca_pkg::A_INIT_ALLOC;
							state_d = S_ALLOC_RD;
						end
					end
					fca_pkg::OP_RESIZE: begin
						if (stat.cnt_zero) cmd.st = fca_pkg::ST_ZERO;
						else if (stat.ent_zero || stat.ent_rng) cmd.st = fca_pkg::ST_RANGE;
						else begin
							cmd.res_ld = 1'b0;
							cmd.act = fca_pkg::A_INIT_CHAIN;
							state_d = S_CHK_RD;
						end
					end
					fca_pkg::OP_FREE, fca_pkg::OP_COUNT: begin
						if (stat.ent_zero || stat.ent_rng) cmd.st = fca_pkg::ST_RANGE;
						else begin
							cmd.res_ld = 1'b0;
							cmd.act = fca_pkg::A_INIT_CHAIN;
							state_d = S_WALK_RD;
						end
					end
					fca_pkg::OP_NEXT: begin
						if (stat.ent_rng) cmd.st = fca_pkg::ST_RANGE;
						else begin
							cmd.res_ld = 1'b0;
							cmd.act = fca_pkg::A_INIT_CHAIN;
							state_d = S_NL_RD;
						end
					end
					fca_pkg::OP_CLUSTER: begin
						if (stat.ent_rng) cmd.st = fca_pkg::ST_RANGE;
						else cmd.vsel = fca_pkg::V_CLU;
					end
					default: cmd.st = fca_pkg::ST_RANGE;
				endcase
			end
			// Format sweep, one entry a cycle
			S_FMT: begin
				cmd.act = fca_pkg::A_FMT_STEP;
				if (stat.fmt_last) begin
					cmd.res_ld = 1'b1;
					state_d = S_DONE;
				end
			end
			S_CHK_RD: state_d = S_CHK_EV;
			// Resize: walk up to the requested length or the chain end
			S_CHK_EV: begin
				if (stat.rd_zero) begin
					if (stat.len_eq_cnt) begin
						cmd.res_ld = 1'b1;
						cmd.vsel = fca_pkg::V_CNT;
						state_d = S_DONE;
					end else if (stat.fh_zero) begin
						cmd.res_ld = 1'b1;
						cmd.st = fca_pkg::ST_NOSPACE;
						state_d = S_DONE;
					end else if (stat.fh_rng) begin
						cmd.res_ld = 1'b1;
						cmd.st = fca_pkg::ST_RANGE;
						state_d = S_DONE;
					end else begin
						cmd.act = fca_pkg::A_INIT_GROW;
						state_d = S_ALLOC_RD;
					end
				end else if (stat.len_eq_cnt) begin
					if (stat.rd_rng) begin
						cmd.res_ld = 1'b1;
						cmd.st = fca_pkg::ST_RANGE;
						state_d = S_DONE;
					end else begin
						cmd.act = fca_pkg::A_MARK_CUT;
						state_d = S_WALK_RD;
					end
				end else if (stat.rd_rng || stat.len_full) begin
					cmd.res_ld = 1'b1;
					cmd.st = fca_pkg::ST_RANGE;
					state_d = S_DONE;
				end else begin
					cmd.act = fca_pkg::A_STEP_LEN;
					state_d = S_CHK_RD;
				end
			end
			S_ALLOC_RD: state_d = S_ALLOC_EV;
			// Free list walk and allocation commit
			S_ALLOC_EV: begin
				if (stat.k_one) begin
					if (stat.rd_rng) begin
						cmd.res_ld = 1'b1;
						cmd.st = fca_pkg::ST_RANGE;
						state_d = S_DONE;
					end else begin
						cmd.act = fca_pkg::A_ALLOC_COMMIT;
						if (stat.op == fca_pkg::OP_ALLOC) begin
							cmd.res_ld = 1'b1;
							cmd.vsel = fca_pkg::V_HEAD;
							state_d = S_DONE;
						end else begin
							state_d = S_GROW_WR;
						end
					end
				end else if (stat.rd_zero) begin
					cmd.res_ld = 1'b1;
					cmd.st = fca_pkg::ST_NOSPACE;
					state_d = S_DONE;
				end else if (stat.rd_rng || stat.vis_full) begin
					cmd.res_ld = 1'b1;
					cmd.st = fca_pkg::ST_RANGE;
					state_d = S_DONE;
				end else begin
					cmd.act = fca_pkg::A_STEP_ALLOC;
					state_d = S_ALLOC_RD;
				end
			end
			S_GROW_WR: begin
				cmd.act = fca_pkg::A_GROW_LINK;
				cmd.res_ld = 1'b1;
				cmd.vsel = fca_pkg::V_CNT;
				state_d = S_DONE;
			end
			S_WALK_RD: state_d = S_WALK_EV;
			// Walk to the chain end
			S_WALK_EV: begin
				if (stat.rd_zero) begin
					case (stat.op)
						fca_pkg::OP_RESIZE: state_d = S_CUT_WR;
						fca_pkg::OP_FREE: state_d = S_END_WR;
						default: begin
							cmd.res_ld = 1'b1;
							cmd.vsel = fca_pkg::V_LEN;
							state_d = S_DONE;
						end
					endcase
				end else if (stat.rd_rng || stat.len_full) begin
					cmd.res_ld = 1'b1;
					cmd.st = fca_pkg::ST_RANGE;
					state_d = S_DONE;
				end else begin
					cmd.act = fca_pkg::A_STEP_LEN;
					state_d = S_WALK_RD;
				end
			end
			S_CUT_WR: begin
				cmd.act = fca_pkg::A_WR_CUT;
				state_d = S_END_WR;
			end
			S_END_WR: begin
				cmd.act = fca_pkg::A_WR_END;
				cmd.res_ld = 1'b1;
				cmd.vsel = (stat.op == fca_pkg::OP_RESIZE) ? fca_pkg::V_CNT : fca_pkg::V_ZERO;
				state_d = S_DONE;
			end
			S_NL_RD: state_d = S_NL_EV;
			S_NL_EV: begin
				cmd.res_ld = 1'b1;
				if (stat.rd_zero) cmd.st = fca_pkg::ST_END;
				else cmd.vsel = fca_pkg::V_RD;
				state_d = S_DONE;
			end
			// Hand the result to the output register
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* src/fca_dp.sv */
// Datapath of the chain allocator: link memory, walk registers, result.
// Depends on fca_pkg; commanded by fca_ctrl.
`default_nettype none

module fca_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [fca_pkg::CW-1:0] cfg_wdata,
	input wire logic [fca_pkg::OW-1:0] in_op,
	input wire logic [fca_pkg::AW-1:0] in_entry,
	input wire logic [fca_pkg::CW-1:0] in_count,
	input wire fca_pkg::cmd_t cmd,
	output fca_pkg::dp_stat_t stat,
	output logic [fca_pkg::SW-1:0] out_status,
	output logic [fca_pkg::VW-1:0] out_value
);

	localparam int AW = fca_pkg::AW;
	localparam int CW = fca_pkg::CW;
	localparam int VW = fca_pkg::VW;
	localparam logic [CW-1:0] MAXN = CW'(fca_pkg::MAX_ENTRIES);

	logic [AW-1:0] mem [fca_pkg::MAX_ENTRIES];
	logic [AW-1:0] rd_q;
	logic [CW-1:0] ecount_q;
	logic [AW-1:0] fh_q;
	logic [fca_pkg::OW-1:0] op_q;
	logic [AW-1:0] ent_q, cur_q, pos_q, tail_q, head_q, idx_q;
	logic [CW-1:0] cnt_q, len_q, vis_q, k_q;
	logic [fca_pkg::SW-1:0] res_st_q;
	logic [VW-1:0] res_val_q;

	logic [CW-1:0] n;
	logic we;
	logic [AW-1:0] wa, wd, fmt_val;
	logic [VW:0] clu;
	logic [VW-1:0] sel_val;

	// Effective table size
	always_comb begin
		if (ecount_q < CW'(2)) n = CW'(2);
		else if (ecount_q > MAXN) n = MAXN;
		else n = ecount_q;
	end

	// Status to the controller
	assign stat.op = op_q;
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.ent_zero = (ent_q == '0);
	assign stat.ent_rng = ({1'b0, ent_q} >= n);
	assign stat.fh_zero = (fh_q == '0);
	assign stat.fh_rng = ({1'b0, fh_q} >= n);
	assign stat.rd_zero = (rd_q == '0);
	assign stat.rd_rng = ({1'b0, rd_q} >= n);
	assign stat.len_eq_cnt = (len_q == cnt_q);
	assign stat.len_full = (len_q >= n);
	assign stat.vis_full = (vis_q >= n);
	assign stat.k_one = (k_q == CW'(1));
	assign stat.fmt_last = ({1'b0, idx_q} == n - CW'(1));

	// Format link: entry 0 and the last entry end, others point on
	assign fmt_val = (idx_q == '0 || stat.fmt_last) ? '0 : idx_q + AW'(1);

	// Memory write port
	always_comb begin
		we = 1'b1;
		wa = cur_q;
		wd = '0;
		case (cmd.act)
			fca_pkg::A_FMT_STEP: begin
				wa = idx_q;
				wd = fmt_val;
			end
			fca_pkg::A_ALLOC_COMMIT: wa = cur_q;
			fca_pkg::A_GROW_LINK: begin
				wa = pos_q;
				wd = head_q;
			end
			fca_pkg::A_WR_CUT: wa = pos_q;
			fca_pkg::A_WR_END: wd = fh_q;
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[cur_q];
	end

	// Cluster number, saturated
	assign clu = (VW+1)'(2) + (VW+1)'((n - CW'(1)) / fca_pkg::ENTRIES_PER_CLUSTER)
		+ (VW+1)'(ent_q);

	always_comb begin
		case (cmd.vsel)
			fca_pkg::V_HEAD: sel_val = VW'(head_q);
			fca_pkg::V_CNT: sel_val = VW'(cnt_q);
			fca_pkg::V_LEN: sel_val = VW'(len_q);
			fca_pkg::V_RD: sel_val = VW'(rd_q);
			fca_pkg::V_CLU: sel_val = clu[VW] ? '1 : clu[VW-1:0];
			default: sel_val = '0;
		endcase
	end

	// Config register and free list head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecount_q <= MAXN;
			fh_q <= '0;
		end else begin
			if (cfg_we) ecount_q <= cfg_wdata;
			case (cmd.act)
				fca_pkg::A_FMT_STEP: if (stat.fmt_last) fh_q <= AW'(1);
				fca_pkg::A_ALLOC_COMMIT: fh_q <= rd_q;
				fca_pkg::A_WR_END: fh_q <= tail_q;
				default: ;
			endcase
		end
	end

	// Walk registers
	always_ff @(posedge clk) begin
		case (cmd.act)
			fca_pkg::A_LOAD: begin
				op_q <= in_op;
				ent_q <= in_entry;
				cnt_q <= in_count;
				idx_q <= '0;
			end
			fca_pkg::A_INIT_CHAIN: begin
				cur_q <= ent_q;
				tail_q <= ent_q;
				len_q <= CW'(1);
			end
			fca_pkg::A_INIT_ALLOC: begin
				cur_q <= fh_q;
				head_q <= fh_q;
				k_q <= cnt_q;
				vis_q <= CW'(1);
			end
			fca_pkg::A_INIT_GROW: begin
				cur_q <= fh_q;
				head_q <= fh_q;
				pos_q <= cur_q;
				k_q <= cnt_q - len_q;
				vis_q <= CW'(1);
			end
			fca_pkg::A_STEP_LEN: begin
				cur_q <= rd_q;
				len_q <= len_q + CW'(1);
			end
			fca_pkg::A_STEP_ALLOC: begin
				cur_q <= rd_q;
				k_q <= k_q - CW'(1);
				vis_q <= vis_q + CW'(1);
			end
			fca_pkg::A_MARK_CUT: begin
				pos_q <= cur_q;
				tail_q <= rd_q;
				cur_q <= rd_q;
				len_q <= CW'(1);
			end
			fca_pkg::A_FMT_STEP: idx_q <= idx_q + AW'(1);
			default: ;
		endcase
		if (cmd.res_ld) begin
			res_st_q <= cmd.st;
			res_val_q <= (cmd.st == fca_pkg::ST_OK) ? sel_val : '0;
		end
		if (cmd.out_ld) begin
			out_status <= res_st_q;
			out_value <= res_val_q;
		end
	end

endmodule

`default_nettype wire

/* src/fat_chain_allocator.sv */
// Chain allocator over a table of next-entry links with a free list.
// Each operation yields one result; format sweeps every entry of the table, and walks
// visit each link with a registered read of the single link memory and then an
// evaluation, with decode and write-back around them; a resize can walk both the
// chain and the free list. Cluster address and error checks on the inputs are
// answered from the decode state without a walk. One item is worked on at a time; a
// new item is taken while the previous result waits at the output. The link memory
// has no clearing pass: it is defined once a format has written it.
// Depends on fca_pkg, fca_if, fca_ctrl and fca_dp.
`default_nettype none

module fat_chain_allocator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [fca_pkg::CW-1:0] cfg_wdata,
	fca_in_if.sink in_ch,
	fca_out_if.source out_ch
);

	fca_pkg::cmd_t cmd;
	fca_pkg::dp_stat_t stat;
	logic in_ready, out_valid;
	logic [fca_pkg::SW-1:0] out_status;
	logic [fca_pkg::VW-1:0] out_value;

	fca_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ch.ready),
		.stat(stat),
		.cmd(cmd)
	);

	fca_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_op(in_ch.op),
		.in_entry(in_ch.entry),
		.in_count(in_ch.count),
		.cmd(cmd),
		.stat(stat),
		.out_status(out_status),
		.out_value(out_value)
	);

	assign in_ch.ready = in_ready;
	assign out_ch.valid = out_valid;
	assign out_ch.status = out_status;
	assign out_ch.value = out_value;

endmodule

`default_nettype wire

/* src/fca_checker.sv */
// Port-level checker of the chain allocator, bound to the top level.
// Depends on fat_chain_allocator_assert.svh and fca_pkg.
`default_nettype none
`include "fat_chain_allocator_assert.svh"

module fca_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [fca_pkg::SW-1:0] out_status,
	input wire logic [fca_pkg::VW-1:0] out_value
);

	// A stalled result stays offered
	`FCA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_value))
	// Status is one of the defined codes
	`FCA_ASSERT_NOW(a_status_code, out_valid, out_status <= fca_pkg::ST_END)
	// Errors carry a zero value
	`FCA_ASSERT_NOW(a_err_zero, out_valid && out_status != fca_pkg::ST_OK, out_value == '0)
	// One transaction in work at a time
	`FCA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_status(out_ch.status),
	.out_value(out_ch.value)
);

`default_nettype wire
